>>> rtl/mtika_pkg.sv
`timescale 1ns / 1ps
// Shared constants of the MTI/A0 modular exponentiation engine.
// No dependencies.
package mtika_pkg;

  localparam int DefaultWidth = 32;

  localparam int ModulusReset   = 3;
  localparam int GeneratorReset = 2;

  localparam logic CfgModulus   = 1'b0;
  localparam logic CfgGenerator = 1'b1;

  localparam logic FuncPublic = 1'b0;
  localparam logic FuncShared = 1'b1;

endpackage

>>> rtl/mtika_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle.
// Requires a below m (or a of one); no package dependencies.
module mtika_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] r_o
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] b_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH+1:0] red;

  // The doubled accumulator plus the addend stays below three times m.
  always_comb begin
    m1  = {2'b00, m_i};
    m2  = {1'b0, m_i, 1'b0};
    sum = {1'b0, acc_q, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WIDTH - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= red[WIDTH-1:0];
      b_q   <= {b_q[WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign r_o    = acc_q;

endmodule

>>> rtl/mti_key_agreement_modexp.sv
`timescale 1ns / 1ps
// MTI/A0 modular exponentiation engine; uses mtika_pkg and mtika_mulmod.
// Every multiplication, including the initial reduction of a base, runs in the
// shared bit-serial multiplier. Func 0 needs one reduction plus one product
// per set exponent bit and one squaring per bit below the top set bit; func 1
// takes two such powers plus one product.
// One request is worked on at a time; the next is taken once the engine is
// idle, while an earlier result may still wait at the output register.
// Reset sets modulus to 3 and generator to 2 and clears all control state.
module mti_key_agreement_modexp
  import mtika_pkg::*;
#(
  parameter int WIDTH = DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [WIDTH-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  logic [WIDTH-1:0] exp_first_i,
  input  logic [WIDTH-1:0] exp_second_i,
  input  logic [WIDTH-1:0] base_first_i,
  input  logic [WIDTH-1:0] base_second_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] value_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_LOOP,
    S_MACC,
    S_SQR,
    S_FIN,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [WIDTH-1:0] modulus_q;
  logic [WIDTH-1:0] generator_q;
  logic             func_q;
  logic             phase_q;
  logic [WIDTH-1:0] exp_q;
  logic [WIDTH-1:0] exp_second_q;
  logic [WIDTH-1:0] base_second_q;
  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] sq_q;
  logic [WIDTH-1:0] p1_q;
  logic [WIDTH-1:0] res_q;
  logic [WIDTH-1:0] value_q;
  logic             out_valid_q;
  logic             mm_start_q;
  logic [WIDTH-1:0] mm_a_q;
  logic [WIDTH-1:0] mm_b_q;
  logic             mm_done;
  logic [WIDTH-1:0] mm_r;
  logic [WIDTH-1:0] one;

  assign one = WIDTH'(modulus_q != WIDTH'(1));

  mtika_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start_q),
    .a_i     (mm_a_q),
    .b_i     (mm_b_q),
    .m_i     (modulus_q),
    .done_o  (mm_done),
    .r_o     (mm_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= WIDTH'(ModulusReset);
      generator_q <= WIDTH'(GeneratorReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgModulus:   modulus_q   <= cfg_wdata_i;
        CfgGenerator: generator_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mm_start_q  <= 1'b0;
      phase_q     <= 1'b0;
      func_q      <= FuncPublic;
    end else begin
      out_valid_q <= (state_q == S_DONE) || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          mm_start_q <= in_valid_i && (modulus_q != '0);
          if (in_valid_i) begin
            func_q        <= func_i;
            phase_q       <= 1'b0;
            exp_q         <= exp_first_i;
            exp_second_q  <= exp_second_i;
            base_second_q <= base_second_i;
            if (modulus_q == '0) begin
              res_q   <= '0;
              state_q <= S_DONE;
            end else begin
              mm_a_q     <= WIDTH'(1);
              mm_b_q     <= (func_i == FuncShared) ? base_first_i : generator_q;
              state_q    <= S_RED;
            end
          end
        end
        S_RED: begin
          mm_start_q <= 1'b0;
          if (mm_done) begin
            sq_q    <= mm_r;
            acc_q   <= one;
            state_q <= S_LOOP;
          end
        end
        S_LOOP: begin
          mm_start_q <= (exp_q != '0) || (func_q == FuncShared);
          if (exp_q == '0) begin
            if (func_q == FuncShared && !phase_q) begin
              p1_q    <= acc_q;
              phase_q <= 1'b1;
              exp_q   <= exp_second_q;
              mm_a_q  <= WIDTH'(1);
              mm_b_q  <= base_second_q;
              state_q <= S_RED;
            end else if (func_q == FuncShared) begin
              mm_a_q  <= p1_q;
              mm_b_q  <= acc_q;
              state_q <= S_FIN;
            end else begin
              res_q      <= acc_q;
              state_q    <= S_DONE;
            end
          end else if (exp_q[0]) begin
            mm_a_q  <= acc_q;
            mm_b_q  <= sq_q;
            state_q <= S_MACC;
          end else begin
            mm_a_q  <= sq_q;
            mm_b_q  <= sq_q;
            state_q <= S_SQR;
          end
        end
        S_MACC: begin
          mm_start_q <= mm_done && (exp_q[WIDTH-1:1] != '0);
          if (mm_done) begin
            acc_q <= mm_r;
            if (exp_q[WIDTH-1:1] == '0) begin
              exp_q   <= '0;
              state_q <= S_LOOP;
            end else begin
              mm_a_q     <= sq_q;
              mm_b_q     <= sq_q;
              state_q    <= S_SQR;
            end
          end
        end
        S_SQR: begin
          mm_start_q <= 1'b0;
          if (mm_done) begin
            sq_q    <= mm_r;
            exp_q   <= {1'b0, exp_q[WIDTH-1:1]};
            state_q <= S_LOOP;
          end
        end
        S_FIN: begin
          mm_start_q <= 1'b0;
          if (mm_done) begin
            res_q   <= mm_r;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          mm_start_q <= 1'b0;
          if (!out_valid_q || !out_stall_i) begin
            value_q     <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          mm_start_q <= 1'b0;
          state_q    <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (state_q == S_RED || state_q == S_MACC ||
                 state_q == S_SQR || state_q == S_FIN))
    else $error("multiplier finished outside a wait state");

  a_loop_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOP |-> (acc_q < modulus_q && sq_q < modulus_q))
    else $error("power operands not reduced");

  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && modulus_q != '0) |-> value_q < modulus_q)
    else $error("result not below modulus");

endmodule
